[rtl/hbc_pkg.sv]
// ----------------------------------------------------------------------------
// hbc_pkg
// Types, constants and helpers shared by the heartbeat collector files.
// ----------------------------------------------------------------------------
package hbc_pkg;

  localparam int unsigned ACC_W       = 43;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned DIV_W       = 16;
  localparam int unsigned SLOT_BITS   = 7;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [7:0]       MARK_LOW        = 8'hA0;
  localparam logic [7:0]       MARK_MID        = 8'hA1;
  localparam logic [7:0]       MARK_HIGH       = 8'hA2;
  localparam logic [DIV_W-1:0] DEFAULT_DIVIDER = DIV_W'(10);

  typedef logic [ACC_W-1:0]   acc_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [DIV_W-1:0]   div_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLLECT_MODE = CFG_IDX_W'(0),
    REG_TICK_DIVIDER = CFG_IDX_W'(1)
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STEP_IDLE = 2'd0,
    STEP_MID  = 2'd1,
    STEP_HIGH = 2'd2
  } chain_step_t;

  typedef struct packed {
    logic       mode;
    logic       full_group;
    logic [7:0] status_byte;
    logic [7:0] high_data;
    logic [7:0] low_data;
  } in_item_t;

  typedef struct packed {
    logic   first_traffic;
    logic   traffic_ack;
    logic   heartbeat_send;
    value_t heartbeat_value;
  } out_item_t;

  typedef struct packed {
    logic collect_mode;
    div_t tick_divider;
  } cfg_t;

  // Place a data byte pair into slot pair k of the remote value.
  function automatic acc_t slot_pair(input int unsigned k, input logic [7:0] hi,
                                     input logic [7:0] lo);
    acc_t lo_w;
    acc_t hi_w;
    lo_w = ACC_W'(lo);
    hi_w = ACC_W'(hi);
    return (lo_w << (SLOT_BITS * (2 * k))) | (hi_w << (SLOT_BITS * (2 * k + 1)));
  endfunction

endpackage

[rtl/hbc_channels.sv]
// ----------------------------------------------------------------------------
// hbc channels
// Valid/ready channel interfaces for items, results and register writes.
// ----------------------------------------------------------------------------
interface hbc_item_if import hbc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface hbc_result_if import hbc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface hbc_cfg_if import hbc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/hbc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// hbc_cfg_regs
// Configuration registers: collect mode and tick divider.
// ----------------------------------------------------------------------------
module hbc_cfg_regs import hbc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  hbc_cfg_if.sink   cfg,
  output cfg_t      settings
);

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      settings.collect_mode <= 1'b1;
      settings.tick_divider <= DEFAULT_DIVIDER;
    end else if (wr) begin
      unique case (cfg.index)
        REG_COLLECT_MODE: settings.collect_mode <= cfg.data[0];
        REG_TICK_DIVIDER: settings.tick_divider <= cfg.data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/hbc_core.sv]
// ----------------------------------------------------------------------------
// hbc_core
// Heartbeat state and the per-item update, one item per fire.
// ----------------------------------------------------------------------------
module hbc_core import hbc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_t      settings,
  output out_item_t result
);

  chain_step_t chain_step, chain_step_next;
  acc_t        remote_acc, remote_acc_next;
  value_t      pending, pending_next;
  logic        send_pending, send_pending_next;
  logic        traffic_seen, traffic_seen_next;
  logic        ever_traffic, ever_traffic_next;
  value_t      local_counter, local_counter_next;
  div_t        countdown, countdown_next;

  value_t      counter_inc;
  acc_t        acc_full;

  assign counter_inc = local_counter + VALUE_W'(1);
  assign acc_full    = remote_acc | slot_pair(2, item.high_data, item.low_data);

  always_comb begin
    chain_step_next    = chain_step;
    remote_acc_next    = remote_acc;
    pending_next       = pending;
    send_pending_next  = send_pending;
    traffic_seen_next  = traffic_seen;
    ever_traffic_next  = ever_traffic;
    local_counter_next = local_counter;
    countdown_next     = countdown;
    result             = '0;

    if (!item.mode) begin
      traffic_seen_next    = 1'b1;
      result.first_traffic = !ever_traffic;
      ever_traffic_next    = 1'b1;
      if (item.full_group && settings.collect_mode) begin
        unique case (chain_step)
          STEP_MID: begin
            if (item.status_byte == MARK_MID) begin
              remote_acc_next = remote_acc | slot_pair(1, item.high_data, item.low_data);
              chain_step_next = STEP_HIGH;
            end else begin
              chain_step_next = STEP_IDLE;
            end
          end
          STEP_HIGH: begin
            if (item.status_byte == MARK_HIGH && !send_pending) begin
              remote_acc_next    = acc_full;
              pending_next       = VALUE_W'(acc_full) + local_counter;
              local_counter_next = counter_inc;
              send_pending_next  = 1'b1;
            end
            chain_step_next = STEP_IDLE;
          end
          default: begin
            // idle, and the unused code, restart the chain
            chain_step_next = STEP_IDLE;
            if (item.status_byte == MARK_LOW) begin
              remote_acc_next = slot_pair(0, item.high_data, item.low_data);
              chain_step_next = STEP_MID;
            end
          end
        endcase
      end
    end else begin
      if (traffic_seen) begin
        result.traffic_ack = 1'b1;
        traffic_seen_next  = 1'b0;
      end
      if (settings.collect_mode) begin
        if (send_pending) begin
          result.heartbeat_send  = 1'b1;
          result.heartbeat_value = pending;
          send_pending_next      = 1'b0;
        end
      end else if (countdown <= DIV_W'(1)) begin
        countdown_next = (settings.tick_divider == '0) ? DIV_W'(1) : settings.tick_divider;
        local_counter_next     = counter_inc;
        result.heartbeat_send  = 1'b1;
        result.heartbeat_value = counter_inc;
      end else begin
        countdown_next = countdown - DIV_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_step    <= STEP_IDLE;
      remote_acc    <= '0;
      pending       <= '0;
      send_pending  <= 1'b0;
      traffic_seen  <= 1'b0;
      ever_traffic  <= 1'b0;
      local_counter <= '0;
      countdown     <= DEFAULT_DIVIDER;
    end else if (fire) begin
      chain_step    <= chain_step_next;
      remote_acc    <= remote_acc_next;
      pending       <= pending_next;
      send_pending  <= send_pending_next;
      traffic_seen  <= traffic_seen_next;
      ever_traffic  <= ever_traffic_next;
      local_counter <= local_counter_next;
      countdown     <= countdown_next;
    end
  end

  a_first_once: assert property (@(posedge clk) disable iff (rst)
    result.first_traffic |-> !ever_traffic)
    else $error("first traffic pulse after traffic was already seen");

  a_group_marks: assert property (@(posedge clk) disable iff (rst)
    fire && !item.mode |=> ever_traffic && traffic_seen)
    else $error("group did not mark traffic");

  a_send_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.mode && settings.collect_mode |=> !send_pending)
    else $error("pending heartbeat survived a tick in collect mode");

  a_value_quiet: assert property (@(posedge clk) disable iff (rst)
    !result.heartbeat_send |-> result.heartbeat_value == '0)
    else $error("heartbeat value driven without a send");

  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    fire && !item.mode && !settings.collect_mode |=> $stable(local_counter))
    else $error("local counter moved on a group in local mode");

endmodule

[rtl/heartbeat_collector_top.sv]
// ----------------------------------------------------------------------------
// heartbeat_collector_top
// Collects a remote heartbeat chain from MIDI groups, or sends a local
// counter on periodic ticks, and reports traffic.
// ----------------------------------------------------------------------------
//
//  channel   role   payload                                          handshake
//  items     sink   mode, full_group, status_byte, high_data,        valid/ready
//                   low_data
//  results   source first_traffic, traffic_ack, heartbeat_send,      valid/ready
//                   heartbeat_value
//  cfg       sink   index (0 collect_mode, 1 tick_divider), data     valid/ready,
//                                                                    always ready
//
//  One item a cycle sustained while results.ready holds; each item gives exactly
//  one result, registered in the input register and then the result register.
//  The rate is set by the state update in the core: two 64-bit adds per item.
//  Reset (rst, synchronous) empties both registers and returns all state,
//  collect_mode to 1 and tick_divider to 10. No clearing pass is needed.
//  A stalled result holds in the result register; the input register still
//  takes one more item, after which items.ready follows results.ready.
//
module heartbeat_collector_top import hbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  hbc_item_if.sink    items,
  hbc_result_if.source results,
  hbc_cfg_if.sink     cfg
);

  cfg_t      settings;
  logic      stage_valid;
  in_item_t  stage_item;
  logic      res_valid;
  out_item_t res_item;
  out_item_t core_result;
  logic      advance;
  logic      fire;

  // Register file for collect mode and divider.
  hbc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .settings (settings)
  );

  // Result register moves whenever it is empty or being taken.
  assign advance     = !res_valid || results.ready;
  assign fire        = stage_valid && advance;
  assign items.ready = !stage_valid || advance;

  // Input register: hold the item until the core consumes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (items.valid && items.ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      stage_item <= items.item;
    end
  end

  // State update and result for the staged item.
  hbc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (stage_item),
    .settings (settings),
    .result   (core_result)
  );

  // Result register: advance on fire, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_item <= core_result;
    end
  end

  assign results.valid = res_valid;
  assign results.item  = res_item;

endmodule
